@@ src/xml_text_run_extractor_macros.svh @@
// Assertion macros shared by the text run extractor modules.
`ifndef XML_TEXT_RUN_EXTRACTOR_MACROS_SVH
`define XML_TEXT_RUN_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XTR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define XTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/xtr_pkg.sv @@
// Types, tag tables and codes for the text run extractor.
package xtr_pkg;

  // Tag mode codes; any other code selects plain t tags
  localparam logic [1:0] MODE_W = 2'd0;
  localparam logic [1:0] MODE_A = 2'd1;
  localparam logic [1:0] MODE_T = 2'd2;

  localparam logic [7:0] CHAR_LT = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_GT = 8'h3E;  // '>'

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_e;

  // Final result of one command, if any
  typedef enum logic [1:0] {
    FIN_NONE   = 2'd0,
    FIN_CLOSED = 2'd1,
    FIN_UNTERM = 2'd2
  } fin_e;

  // One classified input byte, expanded by the back end into results:
  // rel1 held tag bytes, then the byte itself if emit_b, then rel2 held
  // tag bytes, then the final result.
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] rel1;
    logic       emit_b;
    logic [7:0] data;
    logic [2:0] rel2;
    fin_e       fin;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
  } q_stat_t;

  function automatic logic [2:0] open_len(input logic [1:0] mode);
    case (mode)
      MODE_W:  open_len = 3'd4;
      MODE_A:  open_len = 3'd4;
      default: open_len = 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] close_len(input logic [1:0] mode);
    case (mode)
      MODE_W:  close_len = 3'd6;
      MODE_A:  close_len = 3'd6;
      default: close_len = 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] open_byte(input logic [1:0] mode, input logic [2:0] idx);
    logic [7:0] letter;
    letter = (mode == MODE_A) ? 8'h61 : 8'h77;  // 'a' or 'w'
    if (mode == MODE_W || mode == MODE_A) begin
      case (idx)
        3'd0:    open_byte = CHAR_LT;
        3'd1:    open_byte = letter;
        3'd2:    open_byte = 8'h3A;  // ':'
        3'd3:    open_byte = 8'h74;  // 't'
        default: open_byte = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    open_byte = CHAR_LT;
        3'd1:    open_byte = 8'h74;
        default: open_byte = 8'h00;
      endcase
    end
  endfunction

  function automatic logic [7:0] close_byte(input logic [1:0] mode, input logic [2:0] idx);
    logic [7:0] letter;
    letter = (mode == MODE_A) ? 8'h61 : 8'h77;
    if (mode == MODE_W || mode == MODE_A) begin
      case (idx)
        3'd0:    close_byte = CHAR_LT;
        3'd1:    close_byte = 8'h2F;  // '/'
        3'd2:    close_byte = letter;
        3'd3:    close_byte = 8'h3A;
        3'd4:    close_byte = 8'h74;
        3'd5:    close_byte = CHAR_GT;
        default: close_byte = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    close_byte = CHAR_LT;
        3'd1:    close_byte = 8'h2F;
        3'd2:    close_byte = 8'h74;
        3'd3:    close_byte = CHAR_GT;
        default: close_byte = 8'h00;
      endcase
    end
  endfunction

endpackage

@@ src/xtr_front.sv @@
// Front end: tag matching state machine, run counter and command build.
module xtr_front import xtr_pkg::*; #(
  parameter int unsigned RUN_LENGTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tag_mode_we_i,
  input  logic [1:0]                 tag_mode_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_stream_i,
  input  q_stat_t                    q_stat_i,
  output logic                       push_o,
  output cmd_t                       cmd_o,
  output logic [RUN_LENGTH_BITS-1:0] len_o
);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_SKIP   = 3'b010,
    PH_TEXT   = 3'b100
  } phase_e;

  localparam logic [RUN_LENGTH_BITS-1:0] RunMax = '1;

  phase_e                     phase_q, phase_d;
  logic [2:0]                 mp_q, mp_d;
  logic [RUN_LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]                 mode_q;

  logic [2:0]                 olen, clen, mp_o, mp_c;
  logic [2:0]                 rel1, rel2, inc;
  logic                       emit_b, closed;
  fin_e                       fin;
  logic [RUN_LENGTH_BITS-1:0] cnt_base, cnt_sat;
  logic [RUN_LENGTH_BITS:0]   cnt_sum;
  logic [2:0]                 total;
  logic                       accept;

  assign olen = open_len(mode_q);
  assign clen = close_len(mode_q);
  // Out-of-range match positions count as zero
  assign mp_o = (mp_q >= olen) ? 3'd0 : mp_q;
  assign mp_c = (mp_q >= clen) ? 3'd0 : mp_q;

  // Per-byte state update and release counts
  always_comb begin
    phase_d  = phase_q;
    mp_d     = mp_q;
    cnt_base = cnt_q;
    rel1     = 3'd0;
    rel2     = 3'd0;
    emit_b   = 1'b0;
    closed   = 1'b0;
    fin      = FIN_NONE;
    case (phase_q)
      PH_SKIP: begin
        if (in_byte_i == CHAR_GT) begin
          phase_d  = PH_TEXT;
          mp_d     = 3'd0;
          cnt_base = '0;
        end
      end
      PH_TEXT: begin
        if (in_byte_i == close_byte(mode_q, mp_c)) begin
          if (mp_c + 3'd1 == clen) begin
            closed  = 1'b1;
            fin     = FIN_CLOSED;
            phase_d = PH_SEARCH;
            mp_d    = 3'd0;
          end else begin
            mp_d = mp_c + 3'd1;
          end
        end else begin
          rel1 = mp_c;
          if (in_byte_i == CHAR_LT) begin
            mp_d = 3'd1;
          end else begin
            mp_d   = 3'd0;
            emit_b = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_SEARCH;
        if (in_byte_i == open_byte(mode_q, mp_o)) begin
          if (mp_o + 3'd1 == olen) begin
            phase_d = PH_SKIP;
            mp_d    = 3'd0;
          end else begin
            mp_d = mp_o + 3'd1;
          end
        end else begin
          mp_d = (in_byte_i == CHAR_LT) ? 3'd1 : 3'd0;
        end
      end
    endcase
    // End of stream cuts an open run
    if (end_of_stream_i) begin
      if (phase_d == PH_TEXT) begin
        rel2 = mp_d;
        fin  = FIN_UNTERM;
      end else if (phase_d == PH_SKIP) begin
        fin  = FIN_UNTERM;
      end
    end
  end

  // Saturating run count over every text byte released by this transaction
  assign inc     = rel1 + {2'd0, emit_b} + rel2;
  assign cnt_sum = {1'b0, cnt_base} + {{(RUN_LENGTH_BITS-2){1'b0}}, inc};
  assign cnt_sat = cnt_sum[RUN_LENGTH_BITS] ? RunMax : cnt_sum[RUN_LENGTH_BITS-1:0];

  assign cnt_d = closed ? '0 : cnt_sat;

  // Command to the queue
  assign total = inc + {2'd0, (fin != FIN_NONE)};
  assign cmd_o = '{mode: mode_q, rel1: rel1, emit_b: emit_b, data: in_byte_i,
                   rel2: rel2, fin: fin};
  always_comb begin
    case (fin)
      FIN_CLOSED: len_o = cnt_q;
      FIN_UNTERM: len_o = (phase_d == PH_TEXT) ? cnt_sat : '0;
      default:    len_o = '0;
    endcase
  end

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (total != 3'd0);

  // State registers; a mode write or end of stream returns to search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      mp_q    <= 3'd0;
      cnt_q   <= '0;
      mode_q  <= MODE_W;
    end else if (tag_mode_we_i) begin
      mode_q  <= tag_mode_wdata_i;
      phase_q <= PH_SEARCH;
      mp_q    <= 3'd0;
      cnt_q   <= '0;
    end else if (accept) begin
      if (end_of_stream_i) begin
        phase_q <= PH_SEARCH;
        mp_q    <= 3'd0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        mp_q    <= mp_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

@@ src/xtr_fifo.sv @@
// Small register queue between the front and back ends.
`include "xml_text_run_extractor_macros.svh"
module xtr_fifo import xtr_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output q_stat_t          stat_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [Width-1:0] head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             full, empty;

  assign full         = (cnt_q == CntFull);
  assign empty        = (cnt_q == '0);
  assign stat_o.full  = full;
  assign head_valid_o = !empty;
  assign head_o       = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `XTR_ASSERT_IMPL(a_no_overflow, push_i, !full, "queue push while full")
  `XTR_ASSERT_IMPL(a_no_underflow, pop_i, !empty, "queue pop while empty")
  `XTR_ASSERT_NEXT(a_push_fills, push_i && !pop_i, !empty, "push left queue empty")

endmodule

@@ src/xtr_back.sv @@
// Back end: a command becomes results in the output register, one per unstalled cycle.
`include "xml_text_run_extractor_macros.svh"
module xtr_back import xtr_pkg::*; #(
  parameter int unsigned RUN_LENGTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  cmd_t                       cmd_i,
  input  logic [RUN_LENGTH_BITS-1:0] len_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 text_byte_o,
  output logic [RUN_LENGTH_BITS-1:0] run_length_o,
  output logic                       last_of_run_o
);

  logic [2:0]                 idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  kind_e                      kind_q, kind_d;
  logic [7:0]                 byte_q, byte_d;
  logic [RUN_LENGTH_BITS-1:0] len_q, len_d;
  logic                       last_q, last_d;

  logic [2:0] p1, p2, p3, total;
  logic       load;

  // Boundaries of the three text segments in the command
  assign p1    = cmd_i.rel1;
  assign p2    = p1 + {2'd0, cmd_i.emit_b};
  assign p3    = p2 + cmd_i.rel2;
  assign total = p3 + {2'd0, (cmd_i.fin != FIN_NONE)};

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_d = (idx_q == total - 3'd1);
  assign pop_o = load && last_d;

  // Result selected by the position within the command
  always_comb begin
    kind_d = KIND_TEXT;
    byte_d = 8'h00;
    len_d  = '0;
    if (idx_q < p1) begin
      byte_d = close_byte(cmd_i.mode, idx_q);
    end else if (idx_q < p2) begin
      byte_d = cmd_i.data;
    end else if (idx_q < p3) begin
      byte_d = close_byte(cmd_i.mode, idx_q - p2);
    end else begin
      kind_d = (cmd_i.fin == FIN_CLOSED) ? KIND_CLOSED : KIND_UNTERM;
      len_d  = len_i;
    end
  end

  assign idx_d       = pop_o ? 3'd0 : idx_q + 3'd1;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        idx_q <= idx_d;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign text_byte_o   = byte_q;
  assign run_length_o  = len_q;
  assign last_of_run_o = last_q;

  `XTR_ASSERT_IMPL(a_idx_range, head_valid_i, idx_q < total, "result index past command")
  `XTR_ASSERT_IMPL(a_idx_idle, !head_valid_i, idx_q == 3'd0, "index moved with no command")
  `XTR_ASSERT_NEXT(a_pop_last, pop_o, out_valid_q && last_q, "pop without final result")

endmodule

@@ src/xml_text_run_extractor.sv @@
// Top level of the markup text run extractor.
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_ready_o     in_byte_i, end_of_stream_i
//   output    out        out_valid_o / out_ready_i   kind_o, text_byte_o,
//                                                    run_length_o, last_of_run_o
//   config    in         tag_mode_we_i               tag_mode_wdata_i
//
// An input byte gives 0 to 7 results, which leave one per cycle from the output
// register while out_ready_i is high; with the output not stalled, sustained rate is
// one byte per cycle when each byte gives at most one result, else one result per cycle.
// An input transaction reaches its first result via the queue, then the output register.
// The two-entry command queue lets input run on while the output stalls.
// Reset is asynchronous, active low; no clearing pass is needed.
module xml_text_run_extractor import xtr_pkg::*; #(
  parameter int unsigned RUN_LENGTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tag_mode_we_i,
  input  logic [1:0]                 tag_mode_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_stream_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 text_byte_o,
  output logic [RUN_LENGTH_BITS-1:0] run_length_o,
  output logic                       last_of_run_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QWidth = CmdW + RUN_LENGTH_BITS;

  q_stat_t                    q_stat;
  logic                       push, pop, head_valid;
  cmd_t                       cmd_in, cmd_head;
  logic [RUN_LENGTH_BITS-1:0] len_in, len_head;
  logic [QWidth-1:0]          head;

  xtr_front #(
    .RUN_LENGTH_BITS(RUN_LENGTH_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_mode_we_i   (tag_mode_we_i),
    .tag_mode_wdata_i(tag_mode_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .cmd_o           (cmd_in),
    .len_o           (len_in)
  );

  xtr_fifo #(
    .Width(QWidth),
    .Depth(QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     ({cmd_in, len_in}),
    .stat_o      (q_stat),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  assign cmd_head = cmd_t'(head[QWidth-1:RUN_LENGTH_BITS]);
  assign len_head = head[RUN_LENGTH_BITS-1:0];

  xtr_back #(
    .RUN_LENGTH_BITS(RUN_LENGTH_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .cmd_i        (cmd_head),
    .len_i        (len_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .text_byte_o  (text_byte_o),
    .run_length_o (run_length_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
